### hdl/ccm_pkg.sv
// Shared constants for the covariance and correlation matrix engine.
`timescale 1ns / 1ps

package ccm_pkg;

    localparam int MAX_ROWS    = 256;
    localparam int MAX_COLUMNS = 8;
    localparam int STORE_DEPTH = MAX_ROWS * MAX_COLUMNS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int COL_W       = 3;
    localparam int NROWS_W     = 9;
    localparam int NCOLS_W     = 4;
    localparam int LOAD_W      = 12;
    localparam int TOTAL_W     = NROWS_W + NCOLS_W;
    localparam int COV_DEPTH   = MAX_COLUMNS * MAX_COLUMNS;
    localparam int COV_AW      = 2 * COL_W;
    localparam int DIV_W       = 66;
    localparam int DEN_W       = 48;
    localparam int CNT_W       = 7;
    localparam int SQRT_STEPS  = 32;
    localparam int TDATA_W     = 40;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 9;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLUMNS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODE        = 2'd2;

endpackage

### hdl/covariance_correlation_matrix.sv
// Top level: loads a data set and emits its covariance or correlation matrix.
// Loading takes one beat per cycle; the beat that completes the set starts the computation.
// Means are computed one column at a time, then the covariance of each column pair, with a square root on the diagonal.
// In correlation mode each result entry with a nonzero denominator also passes through the divider.
// No beat is taken until every entry of the matrix has been delivered.
// Reset clears the control state and configuration registers; datapath registers and the data memory are not cleared.
`timescale 1ns / 1ps

module covariance_correlation_matrix (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [31:0]                      s_tdata,   // sample[31:0]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [ccm_pkg::TDATA_W-1:0]      m_tdata,   // row_index, col_index, value, zero pad
    output logic                             m_tuser,   // undefined
    output logic                             m_tlast,
    input  logic                             cfg_wr_en,
    input  logic [ccm_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [ccm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam logic [3:0] S_LOAD     = 4'd0;
    localparam logic [3:0] S_MEAN     = 4'd1;
    localparam logic [3:0] S_MEAN_DIV = 4'd2;
    localparam logic [3:0] S_PAIR_A   = 4'd3;
    localparam logic [3:0] S_PAIR_B   = 4'd4;
    localparam logic [3:0] S_ROW      = 4'd5;
    localparam logic [3:0] S_COV_DIV  = 4'd6;
    localparam logic [3:0] S_COV_WR   = 4'd7;
    localparam logic [3:0] S_SQRT     = 4'd8;
    localparam logic [3:0] S_OUT_RD   = 4'd9;
    localparam logic [3:0] S_OUT_CALC = 4'd10;
    localparam logic [3:0] S_OUT_DEN  = 4'd11;
    localparam logic [3:0] S_OUT_DIV  = 4'd12;
    localparam logic [3:0] S_OUT_HOLD = 4'd13;

    localparam int CW = ccm_pkg::COL_W;

    logic [3:0]                    state_reg, state_next;
    logic [ccm_pkg::NROWS_W-1:0]   num_rows_reg, num_rows_next;
    logic [ccm_pkg::NCOLS_W-1:0]   num_cols_reg, num_cols_next;
    logic                          mode_reg, mode_next;
    logic [ccm_pkg::LOAD_W-1:0]    load_cnt_reg, load_cnt_next;
    logic                          m_valid_reg, m_valid_next;

    logic [CW-1:0]                 col_i_reg, col_i_next;
    logic [CW-1:0]                 col_j_reg, col_j_next;
    logic [ccm_pkg::ROW_W-1:0]     row_reg, row_next;
    logic [ccm_pkg::ADDR_W-1:0]    base_reg, base_next;
    logic [2:0]                    step_reg, step_next;
    logic signed [39:0]            sum_reg, sum_next;
    logic signed [63:0]            acc_reg, acc_next;
    logic [31:0]                   mean_a_reg, mean_a_next;
    logic [31:0]                   mean_b_reg, mean_b_next;
    logic signed [32:0]            d1_reg, d1_next;
    logic signed [32:0]            d2_reg, d2_next;
    logic [48:0]                   plo_reg, plo_next;
    logic [49:0]                   phi_reg, phi_next;
    logic                          neg_reg, neg_next;
    logic signed [63:0]            cov_reg, cov_next;
    logic [ccm_pkg::DIV_W-1:0]     div_quo_reg, div_quo_next;
    logic [ccm_pkg::DEN_W-1:0]     div_rem_reg, div_rem_next;
    logic [ccm_pkg::DEN_W-1:0]     div_den_reg, div_den_next;
    logic [ccm_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic [63:0]                   sq_rad_reg, sq_rad_next;
    logic [33:0]                   sq_rem_reg, sq_rem_next;
    logic [31:0]                   sq_res_reg, sq_res_next;
    logic [31:0]                   sd_a_reg, sd_a_next;
    logic [63:0]                   sdprod_reg, sdprod_next;
    logic [CW-1:0]                 out_row_reg, out_row_next;
    logic [CW-1:0]                 out_col_reg, out_col_next;
    logic [31:0]                   out_value_reg, out_value_next;
    logic                          out_undef_reg, out_undef_next;
    logic                          out_last_reg, out_last_next;
    logic [31:0]                   mean_reg [ccm_pkg::MAX_COLUMNS];
    logic [31:0]                   sd_reg [ccm_pkg::MAX_COLUMNS];

    logic                          mean_we, sd_we, data_we, cov_we, pair_done;
    logic [31:0]                   mean_value;
    logic [CW-1:0]                 mean_idx, sd_idx, rd_col;
    logic [31:0]                   mean_rd, sd_rd;
    logic [ccm_pkg::ADDR_W-1:0]    data_raddr;
    logic [31:0]                   data_rdata;
    logic [ccm_pkg::COV_AW-1:0]    cov_raddr;
    logic [63:0]                   cov_rdata;
    logic [ccm_pkg::TOTAL_W-1:0]   total;
    logic                          last_i, last_j, last_row;
    logic signed [39:0]            sum_add;
    logic [39:0]                   sum_mag;
    logic [32:0]                   mag_a, mag_b;
    logic [49:0]                   term;
    logic signed [63:0]            acc_add;
    logic [63:0]                   acc_mag, cov_mag;
    logic [48:0]                   div_trial, div_diff;
    logic                          div_ge;
    logic [35:0]                   sq_cur, sq_trial, sq_diff;
    logic                          sq_ge;
    logic [ccm_pkg::DEN_W-1:0]     den;
    logic [31:0]                   q_sat;
    logic [31:0]                   cov_sat;

    assign total    = ccm_pkg::TOTAL_W'(num_rows_reg) * ccm_pkg::TOTAL_W'(num_cols_reg);
    assign last_i   = (ccm_pkg::NCOLS_W'(col_i_reg) + 1'b1) == num_cols_reg;
    assign last_j   = (ccm_pkg::NCOLS_W'(col_j_reg) + 1'b1) == num_cols_reg;
    assign last_row = (ccm_pkg::NROWS_W'(row_reg) + 1'b1) == num_rows_reg;

    assign rd_col     = (state_reg == S_ROW && step_reg == 3'd0) ? col_i_reg : col_j_reg;
    assign data_raddr = base_reg + ccm_pkg::ADDR_W'(rd_col);
    assign cov_raddr  = (col_i_reg <= col_j_reg) ? {col_i_reg, col_j_reg}
                                                  : {col_j_reg, col_i_reg};

    assign mean_idx = (state_reg == S_PAIR_A) ? col_i_reg : col_j_reg;
    assign mean_rd  = mean_reg[mean_idx];
    assign sd_idx   = (state_reg == S_OUT_RD) ? col_i_reg : col_j_reg;
    assign sd_rd    = sd_reg[sd_idx];

    assign sum_add = sum_reg + {{8{data_rdata[31]}}, data_rdata};
    assign sum_mag = sum_add[39] ? 40'(-sum_add) : 40'(sum_add);

    assign mag_a   = d1_reg[32] ? 33'(-d1_reg) : 33'(d1_reg);
    assign mag_b   = d2_reg[32] ? 33'(-d2_reg) : 33'(d2_reg);
    assign term    = phi_reg + 50'(plo_reg >> 16);
    assign acc_add = neg_reg ? (acc_reg - $signed(64'(term))) : (acc_reg + $signed(64'(term)));
    assign acc_mag = acc_add[63] ? 64'(-acc_add) : 64'(acc_add);
    assign cov_mag = cov_reg[63] ? 64'(-cov_reg) : 64'(cov_reg);

    assign div_trial = {div_rem_reg, div_quo_reg[ccm_pkg::DIV_W-1]};
    assign div_diff  = div_trial - {1'b0, div_den_reg};
    assign div_ge    = div_trial >= {1'b0, div_den_reg};

    assign sq_cur   = {sq_rem_reg, sq_rad_reg[63:62]};
    assign sq_trial = {2'b00, sq_res_reg, 2'b01};
    assign sq_diff  = sq_cur - sq_trial;
    assign sq_ge    = sq_cur >= sq_trial;

    assign den     = sdprod_reg[63:16];
    assign q_sat   = (|div_quo_reg[ccm_pkg::DIV_W-1:31]) ? 32'h8000_0000 : div_quo_reg[31:0];
    assign cov_sat = (cov_reg > 64'sh0000_0000_7FFF_FFFF) ? 32'h7FFF_FFFF :
                     (cov_reg < -64'sh0000_0000_8000_0000) ? 32'h8000_0000 : cov_reg[31:0];

    always_comb
    begin
        state_next     = state_reg;
        num_rows_next  = num_rows_reg;
        num_cols_next  = num_cols_reg;
        mode_next      = mode_reg;
        load_cnt_next  = load_cnt_reg;
        m_valid_next   = m_valid_reg;
        col_i_next     = col_i_reg;
        col_j_next     = col_j_reg;
        row_next       = row_reg;
        base_next      = base_reg;
        step_next      = step_reg;
        sum_next       = sum_reg;
        acc_next       = acc_reg;
        mean_a_next    = mean_a_reg;
        mean_b_next    = mean_b_reg;
        d1_next        = d1_reg;
        d2_next        = d2_reg;
        plo_next       = plo_reg;
        phi_next       = phi_reg;
        neg_next       = neg_reg;
        cov_next       = cov_reg;
        div_quo_next   = div_quo_reg;
        div_rem_next   = div_rem_reg;
        div_den_next   = div_den_reg;
        cnt_next       = cnt_reg;
        sq_rad_next    = sq_rad_reg;
        sq_rem_next    = sq_rem_reg;
        sq_res_next    = sq_res_reg;
        sd_a_next      = sd_a_reg;
        sdprod_next    = sdprod_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_value_next = out_value_reg;
        out_undef_next = out_undef_reg;
        out_last_next  = out_last_reg;
        mean_we        = 1'b0;
        mean_value     = div_quo_reg[31:0];
        sd_we          = 1'b0;
        data_we        = 1'b0;
        cov_we         = 1'b0;
        pair_done      = 1'b0;

        if ((state_reg == S_MEAN_DIV || state_reg == S_COV_DIV || state_reg == S_OUT_DIV)
            && cnt_reg != '0)
        begin
            div_rem_next = div_ge ? div_diff[ccm_pkg::DEN_W-1:0]
                                  : div_trial[ccm_pkg::DEN_W-1:0];
            div_quo_next = {div_quo_reg[ccm_pkg::DIV_W-2:0], div_ge};
            cnt_next     = cnt_reg - 1'b1;
        end

        unique case (state_reg)
            S_LOAD:
            begin
                if (s_tvalid)
                begin
                    data_we = 1'b1;
                    if (ccm_pkg::TOTAL_W'(load_cnt_reg) + 1'b1 == total)
                    begin
                        load_cnt_next = '0;
                        state_next    = S_MEAN;
                        col_j_next    = '0;
                        row_next      = '0;
                        base_next     = '0;
                        step_next     = '0;
                        sum_next      = '0;
                    end
                    else
                    begin
                        load_cnt_next = load_cnt_reg + 1'b1;
                    end
                end
            end
            S_MEAN:
            begin
                if (step_reg == 3'd0)
                begin
                    step_next = 3'd1;
                end
                else
                begin
                    step_next = 3'd0;
                    sum_next  = sum_add;
                    if (last_row)
                    begin
                        div_quo_next = ccm_pkg::DIV_W'(sum_mag)
                                     + ccm_pkg::DIV_W'(num_rows_reg >> 1);
                        div_rem_next = '0;
                        div_den_next = ccm_pkg::DEN_W'(num_rows_reg);
                        cnt_next     = ccm_pkg::CNT_W'(ccm_pkg::DIV_W);
                        neg_next     = sum_add[39];
                        state_next   = S_MEAN_DIV;
                    end
                    else
                    begin
                        row_next  = row_reg + 1'b1;
                        base_next = base_reg + ccm_pkg::ADDR_W'(num_cols_reg);
                    end
                end
            end
            S_MEAN_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    mean_we    = 1'b1;
                    mean_value = neg_reg ? (32'd0 - div_quo_reg[31:0]) : div_quo_reg[31:0];
                    if (last_j)
                    begin
                        col_i_next = '0;
                        col_j_next = '0;
                        state_next = S_PAIR_A;
                    end
                    else
                    begin
                        col_j_next = col_j_reg + 1'b1;
                        row_next   = '0;
                        base_next  = '0;
                        sum_next   = '0;
                        step_next  = '0;
                        state_next = S_MEAN;
                    end
                end
            end
            S_PAIR_A:
            begin
                mean_a_next = mean_rd;
                state_next  = S_PAIR_B;
            end
            S_PAIR_B:
            begin
                mean_b_next = mean_rd;
                acc_next    = '0;
                row_next    = '0;
                base_next   = '0;
                step_next   = '0;
                state_next  = S_ROW;
            end
            S_ROW:
            begin
                unique case (step_reg)
                    3'd0:
                    begin
                        step_next = 3'd1;
                    end
                    3'd1:
                    begin
                        d1_next   = $signed({data_rdata[31], data_rdata})
                                  - $signed({mean_a_reg[31], mean_a_reg});
                        step_next = 3'd2;
                    end
                    3'd2:
                    begin
                        d2_next   = $signed({data_rdata[31], data_rdata})
                                  - $signed({mean_b_reg[31], mean_b_reg});
                        step_next = 3'd3;
                    end
                    3'd3:
                    begin
                        plo_next  = 49'(mag_a) * 49'(mag_b[15:0]);
                        neg_next  = d1_reg[32] ^ d2_reg[32];
                        step_next = 3'd4;
                    end
                    3'd4:
                    begin
                        phi_next  = 50'(mag_a) * 50'(mag_b[32:16]);
                        step_next = 3'd5;
                    end
                    3'd5:
                    begin
                        acc_next  = acc_add;
                        step_next = 3'd0;
                        if (last_row)
                        begin
                            div_quo_next = ccm_pkg::DIV_W'(acc_mag);
                            div_rem_next = '0;
                            div_den_next = ccm_pkg::DEN_W'(num_rows_reg);
                            cnt_next     = ccm_pkg::CNT_W'(ccm_pkg::DIV_W);
                            neg_next     = acc_add[63];
                            state_next   = S_COV_DIV;
                        end
                        else
                        begin
                            row_next  = row_reg + 1'b1;
                            base_next = base_reg + ccm_pkg::ADDR_W'(num_cols_reg);
                        end
                    end
                    default:
                    begin
                        step_next = 3'd0;
                    end
                endcase
            end
            S_COV_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    cov_next   = neg_reg ? -$signed(div_quo_reg[63:0])
                                         : $signed(div_quo_reg[63:0]);
                    state_next = S_COV_WR;
                end
            end
            S_COV_WR:
            begin
                cov_we = 1'b1;
                if (col_i_reg == col_j_reg)
                begin
                    sq_rad_next = 64'(cov_reg) << 16;
                    sq_rem_next = '0;
                    sq_res_next = '0;
                    cnt_next    = ccm_pkg::CNT_W'(ccm_pkg::SQRT_STEPS);
                    state_next  = S_SQRT;
                end
                else
                begin
                    pair_done = 1'b1;
                end
            end
            S_SQRT:
            begin
                if (cnt_reg == '0)
                begin
                    sd_we     = 1'b1;
                    pair_done = 1'b1;
                end
                else
                begin
                    sq_rem_next = sq_ge ? sq_diff[33:0] : sq_cur[33:0];
                    sq_res_next = {sq_res_reg[30:0], sq_ge};
                    sq_rad_next = sq_rad_reg << 2;
                    cnt_next    = cnt_reg - 1'b1;
                end
            end
            S_OUT_RD:
            begin
                sd_a_next  = sd_rd;
                state_next = S_OUT_CALC;
            end
            S_OUT_CALC:
            begin
                cov_next    = $signed(cov_rdata);
                sdprod_next = 64'(sd_a_reg) * 64'(sd_rd);
                state_next  = S_OUT_DEN;
            end
            S_OUT_DEN:
            begin
                out_row_next   = col_i_reg;
                out_col_next   = col_j_reg;
                out_last_next  = last_i && last_j;
                out_undef_next = 1'b0;
                if (!mode_reg)
                begin
                    out_value_next = cov_sat;
                    m_valid_next   = 1'b1;
                    state_next     = S_OUT_HOLD;
                end
                else if (den == '0)
                begin
                    out_value_next = '0;
                    out_undef_next = 1'b1;
                    m_valid_next   = 1'b1;
                    state_next     = S_OUT_HOLD;
                end
                else
                begin
                    div_quo_next = ccm_pkg::DIV_W'(cov_mag) << 16;
                    div_rem_next = '0;
                    div_den_next = den;
                    cnt_next     = ccm_pkg::CNT_W'(ccm_pkg::DIV_W);
                    neg_next     = cov_reg[63];
                    state_next   = S_OUT_DIV;
                end
            end
            S_OUT_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    if (neg_reg)
                    begin
                        out_value_next = 32'd0 - q_sat;
                    end
                    else
                    begin
                        out_value_next = q_sat[31] ? 32'h7FFF_FFFF : q_sat;
                    end
                    m_valid_next = 1'b1;
                    state_next   = S_OUT_HOLD;
                end
            end
            S_OUT_HOLD:
            begin
                if (m_tready)
                begin
                    m_valid_next = 1'b0;
                    if (out_last_reg)
                    begin
                        state_next = S_LOAD;
                    end
                    else if (last_j)
                    begin
                        col_i_next = col_i_reg + 1'b1;
                        col_j_next = '0;
                        state_next = S_OUT_RD;
                    end
                    else
                    begin
                        col_j_next = col_j_reg + 1'b1;
                        state_next = S_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase

        if (pair_done)
        begin
            if (last_j)
            begin
                if (last_i)
                begin
                    col_i_next = '0;
                    col_j_next = '0;
                    state_next = S_OUT_RD;
                end
                else
                begin
                    col_i_next = col_i_reg + 1'b1;
                    col_j_next = col_i_reg + 1'b1;
                    state_next = S_PAIR_A;
                end
            end
            else
            begin
                col_j_next = col_j_reg + 1'b1;
                state_next = S_PAIR_A;
            end
        end

        if (cfg_wr_en)
        begin
            priority if (cfg_addr == ccm_pkg::REG_NUM_ROWS)
            begin
                if (cfg_wdata == '0)
                begin
                    num_rows_next = ccm_pkg::NROWS_W'(1);
                end
                else if (cfg_wdata > ccm_pkg::CFG_DATA_W'(ccm_pkg::MAX_ROWS))
                begin
                    num_rows_next = ccm_pkg::NROWS_W'(ccm_pkg::MAX_ROWS);
                end
                else
                begin
                    num_rows_next = ccm_pkg::NROWS_W'(cfg_wdata);
                end
                load_cnt_next = '0;
            end
            else if (cfg_addr == ccm_pkg::REG_NUM_COLUMNS)
            begin
                if (cfg_wdata == '0)
                begin
                    num_cols_next = ccm_pkg::NCOLS_W'(1);
                end
                else if (cfg_wdata > ccm_pkg::CFG_DATA_W'(ccm_pkg::MAX_COLUMNS))
                begin
                    num_cols_next = ccm_pkg::NCOLS_W'(ccm_pkg::MAX_COLUMNS);
                end
                else
                begin
                    num_cols_next = ccm_pkg::NCOLS_W'(cfg_wdata);
                end
                load_cnt_next = '0;
            end
            else if (cfg_addr == ccm_pkg::REG_MODE)
            begin
                mode_next = cfg_wdata[0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_LOAD;
            num_rows_reg <= ccm_pkg::NROWS_W'(1);
            num_cols_reg <= ccm_pkg::NCOLS_W'(1);
            mode_reg     <= 1'b0;
            load_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            num_rows_reg <= num_rows_next;
            num_cols_reg <= num_cols_next;
            mode_reg     <= mode_next;
            load_cnt_reg <= load_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_i_reg     <= col_i_next;
        col_j_reg     <= col_j_next;
        row_reg       <= row_next;
        base_reg      <= base_next;
        step_reg      <= step_next;
        sum_reg       <= sum_next;
        acc_reg       <= acc_next;
        mean_a_reg    <= mean_a_next;
        mean_b_reg    <= mean_b_next;
        d1_reg        <= d1_next;
        d2_reg        <= d2_next;
        plo_reg       <= plo_next;
        phi_reg       <= phi_next;
        neg_reg       <= neg_next;
        cov_reg       <= cov_next;
        div_quo_reg   <= div_quo_next;
        div_rem_reg   <= div_rem_next;
        div_den_reg   <= div_den_next;
        cnt_reg       <= cnt_next;
        sq_rad_reg    <= sq_rad_next;
        sq_rem_reg    <= sq_rem_next;
        sq_res_reg    <= sq_res_next;
        sd_a_reg      <= sd_a_next;
        sdprod_reg    <= sdprod_next;
        out_row_reg   <= out_row_next;
        out_col_reg   <= out_col_next;
        out_value_reg <= out_value_next;
        out_undef_reg <= out_undef_next;
        out_last_reg  <= out_last_next;
        if (mean_we)
        begin
            mean_reg[col_j_reg] <= mean_value;
        end
        if (sd_we)
        begin
            sd_reg[col_i_reg] <= sq_res_reg;
        end
    end

    ccm_ram #(
        .WIDTH (32),
        .DEPTH (ccm_pkg::STORE_DEPTH)
    ) u_data_ram (
        .clk     (clk),
        .wr_en   (data_we),
        .wr_addr (load_cnt_reg[ccm_pkg::ADDR_W-1:0]),
        .wr_data (s_tdata),
        .rd_addr (data_raddr),
        .rd_data (data_rdata)
    );

    ccm_ram #(
        .WIDTH (64),
        .DEPTH (ccm_pkg::COV_DEPTH)
    ) u_cov_ram (
        .clk     (clk),
        .wr_en   (cov_we),
        .wr_addr ({col_i_reg, col_j_reg}),
        .wr_data (64'(cov_reg)),
        .rd_addr (cov_raddr),
        .rd_data (cov_rdata)
    );

    assign s_tready = (state_reg == S_LOAD);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, out_value_reg, out_col_reg, out_row_reg};
    assign m_tuser  = out_undef_reg;
    assign m_tlast  = out_last_reg;

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input accepted while a result beat is pending");

    a_cov_defined: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !mode_reg) |-> !m_tuser)
        else $error("undefined flag raised in covariance mode");

    a_last_diag: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (out_row_reg == out_col_reg))
        else $error("last beat is not on the diagonal");

    a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD) |-> (ccm_pkg::TOTAL_W'(load_cnt_reg) < total))
        else $error("load count beyond data set size");

endmodule

### hdl/ccm_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module ccm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
